// File: rtl/uep0_pkg.sv
// shared types, constants and descriptor rom for the ep0 request handler
package uep0_pkg;

  // device and rom geometry
  localparam int unsigned NUM_ENDPOINTS    = 4;
  localparam int unsigned EP0_PACKET_BYTES = 8;
  localparam int unsigned DESCRIPTOR_BYTES = 64;
  localparam int unsigned ROM_AW           = $clog2(DESCRIPTOR_BYTES);
  localparam int unsigned LEN_W            = 6;

  // descriptor layout
  localparam logic [ROM_AW-1:0] DEV_DESC_AT  = ROM_AW'(0);
  localparam logic [LEN_W-1:0]  DEV_DESC_LEN = LEN_W'(18);
  localparam logic [ROM_AW-1:0] CFG_DESC_AT  = ROM_AW'(18);
  localparam logic [LEN_W-1:0]  CFG_DESC_LEN = LEN_W'(39);
  localparam logic [ROM_AW-1:0] VID_LO_AT    = ROM_AW'(8);
  localparam logic [ROM_AW-1:0] VID_HI_AT    = ROM_AW'(9);
  localparam logic [ROM_AW-1:0] PID_LO_AT    = ROM_AW'(10);
  localparam logic [ROM_AW-1:0] PID_HI_AT    = ROM_AW'(11);
  localparam logic [LEN_W-1:0]  STATUS_LEN   = LEN_W'(2);
  localparam logic [LEN_W-1:0]  CONFIG_LEN   = LEN_W'(1);

  // command queue
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // request keys, brequest in the high byte and bmrequesttype in the low byte
  localparam logic [15:0] REQ_GET_DESCRIPTOR = 16'h0680;
  localparam logic [15:0] REQ_SET_ADDRESS    = 16'h0500;
  localparam logic [15:0] REQ_SET_CONFIG     = 16'h0900;
  localparam logic [15:0] REQ_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] REQ_GET_STATUS_DEV = 16'h0080;
  localparam logic [15:0] REQ_GET_STATUS_IF  = 16'h0081;
  localparam logic [15:0] REQ_GET_STATUS_EP  = 16'h0082;
  localparam logic [15:0] REQ_CLR_FEAT_IF    = 16'h0101;
  localparam logic [15:0] REQ_SET_FEAT_IF    = 16'h0301;
  localparam logic [15:0] REQ_CLR_FEAT_EP    = 16'h0102;
  localparam logic [15:0] REQ_SET_FEAT_EP    = 16'h0302;
  localparam logic [7:0]  BREQ_SET_FEATURE   = 8'h03;

  localparam logic [15:0] DESC_TYPE_DEVICE = 16'h0100;
  localparam logic [15:0] DESC_TYPE_CONFIG = 16'h0200;

  // configuration register indexes
  localparam logic CFG_VENDOR_ID  = 1'b0;
  localparam logic CFG_PRODUCT_ID = 1'b1;

  typedef enum logic [1:0] {
    RESP_DATA       = 2'd0,
    RESP_ACK        = 2'd1,
    RESP_STALL      = 2'd2,
    RESP_RESET_DONE = 2'd3
  } resp_kind_e;

  typedef enum logic [1:0] {
    DEV_DEFAULT    = 2'd0,
    DEV_ADDRESSED  = 2'd1,
    DEV_CONFIGURED = 2'd2
  } dev_state_e;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [7:0]  setup_request_type;
    logic [7:0]  setup_request;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0] resp_kind;
    logic [7:0] data_byte;
    logic [0:0] last;
    logic [6:0] dev_address;
    logic [1:0] dev_state;
    logic [7:0] config_value;
  } out_item_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    resp_kind_e        kind;
    logic              from_rom;
    logic [ROM_AW-1:0] start;
    logic [LEN_W-1:0]  count;
    logic [7:0]        byte0;
    logic [6:0]        dev_address;
    dev_state_e        dev_state;
    logic [7:0]        config_value;
  } cmd_t;

  // fixed descriptor bytes; identifier bytes are patched in by the back end
  function automatic logic [7:0] desc_rom(input logic [ROM_AW-1:0] pos);
    logic [7:0] b;
    case (pos)
      6'd0:  b = 8'h12;
      6'd1:  b = 8'h01;
      6'd2:  b = 8'h00;
      6'd3:  b = 8'h02;
      6'd4:  b = 8'hFF;
      6'd5:  b = 8'hFF;
      6'd6:  b = 8'hFF;
      6'd7:  b = 8'(EP0_PACKET_BYTES);
      6'd17: b = 8'h01;
      6'd18: b = 8'h09;
      6'd19: b = 8'h02;
      6'd20: b = 8'(CFG_DESC_LEN);
      6'd21: b = 8'h00;
      6'd22: b = 8'h01;
      6'd23: b = 8'h01;
      6'd24: b = 8'h00;
      6'd25: b = 8'h80;
      6'd26: b = 8'd100;
      6'd27: b = 8'h09;
      6'd28: b = 8'h04;
      6'd29: b = 8'h00;
      6'd30: b = 8'h00;
      6'd31: b = 8'h03;
      6'd32: b = 8'hFF;
      6'd33: b = 8'h00;
      6'd34: b = 8'hFF;
      6'd35: b = 8'h00;
      6'd36: b = 8'h07;
      6'd37: b = 8'h05;
      6'd38: b = 8'h01;
      6'd39: b = 8'h02;
      6'd40: b = 8'h40;
      6'd41: b = 8'h00;
      6'd42: b = 8'h00;
      6'd43: b = 8'h07;
      6'd44: b = 8'h05;
      6'd45: b = 8'h82;
      6'd46: b = 8'h02;
      6'd47: b = 8'h40;
      6'd48: b = 8'h00;
      6'd49: b = 8'h00;
      6'd50: b = 8'h07;
      6'd51: b = 8'h05;
      6'd52: b = 8'h83;
      6'd53: b = 8'h03;
      6'd54: b = 8'h40;
      6'd55: b = 8'h00;
      6'd56: b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/uep0_front.sv
// front end: decodes setup transactions, keeps device state, issues commands
module uep0_front #(
  parameter int unsigned NUM_ENDPOINTS = uep0_pkg::NUM_ENDPOINTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  uep0_pkg::in_item_t in_item_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output uep0_pkg::cmd_t     q_cmd_o
);

  localparam int unsigned EPW = 5;

  uep0_pkg::dev_state_e           state_q, state_d;
  logic [6:0]                     addr_q, addr_d;
  logic [7:0]                     conf_q, conf_d;
  logic [NUM_ENDPOINTS-1:1]       halt_q, halt_d;

  logic [15:0]                    key;
  logic [3:0]                     ep;
  logic                           ep_ok;
  logic                           ep_halted;
  logic                           is_data;
  logic [uep0_pkg::LEN_W-1:0]     len_full;
  logic [uep0_pkg::LEN_W-1:0]     len_cut;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign key   = {in_item_i.setup_request, in_item_i.setup_request_type};
  assign ep    = in_item_i.setup_index[3:0];
  assign ep_ok = ({1'b0, ep} < EPW'(NUM_ENDPOINTS));

  always_comb begin
    ep_halted = 1'b0;
    for (int i = 1; i < NUM_ENDPOINTS; i++) begin
      if (ep == 4'(i)) begin
        ep_halted = halt_q[i];
      end
    end
  end

  always_comb begin
    state_d          = state_q;
    addr_d           = addr_q;
    conf_d           = conf_q;
    halt_d           = halt_q;
    is_data          = 1'b0;
    len_full         = '0;
    q_cmd_o.kind     = uep0_pkg::RESP_STALL;
    q_cmd_o.from_rom = 1'b0;
    q_cmd_o.start    = '0;
    q_cmd_o.byte0    = 8'h00;

    if (in_item_i.req_type[0]) begin
      state_d      = uep0_pkg::DEV_DEFAULT;
      addr_d       = '0;
      conf_d       = '0;
      halt_d       = '1;
      q_cmd_o.kind = uep0_pkg::RESP_RESET_DONE;
    end else begin
      case (key)
        uep0_pkg::REQ_GET_DESCRIPTOR: begin
          if (in_item_i.setup_value == uep0_pkg::DESC_TYPE_DEVICE) begin
            is_data          = 1'b1;
            q_cmd_o.from_rom = 1'b1;
            q_cmd_o.start    = uep0_pkg::DEV_DESC_AT;
            len_full         = uep0_pkg::DEV_DESC_LEN;
          end else if (in_item_i.setup_value == uep0_pkg::DESC_TYPE_CONFIG) begin
            is_data          = 1'b1;
            q_cmd_o.from_rom = 1'b1;
            q_cmd_o.start    = uep0_pkg::CFG_DESC_AT;
            len_full         = uep0_pkg::CFG_DESC_LEN;
          end
        end
        uep0_pkg::REQ_SET_ADDRESS: begin
          addr_d       = in_item_i.setup_value[6:0];
          state_d      = (addr_d != '0) ? uep0_pkg::DEV_ADDRESSED : uep0_pkg::DEV_DEFAULT;
          q_cmd_o.kind = uep0_pkg::RESP_ACK;
        end
        uep0_pkg::REQ_SET_CONFIG: begin
          conf_d       = in_item_i.setup_value[7:0];
          state_d      = (conf_d != '0) ? uep0_pkg::DEV_CONFIGURED : uep0_pkg::DEV_ADDRESSED;
          halt_d       = {(NUM_ENDPOINTS-1){conf_d == '0}};
          q_cmd_o.kind = uep0_pkg::RESP_ACK;
        end
        uep0_pkg::REQ_GET_CONFIG: begin
          is_data       = 1'b1;
          q_cmd_o.byte0 = conf_q;
          len_full      = uep0_pkg::CONFIG_LEN;
        end
        uep0_pkg::REQ_GET_STATUS_DEV,
        uep0_pkg::REQ_GET_STATUS_IF: begin
          is_data  = 1'b1;
          len_full = uep0_pkg::STATUS_LEN;
        end
        uep0_pkg::REQ_GET_STATUS_EP: begin
          if (state_q == uep0_pkg::DEV_CONFIGURED && ep_ok) begin
            is_data       = 1'b1;
            q_cmd_o.byte0 = {7'b0, ep_halted};
            len_full      = uep0_pkg::STATUS_LEN;
          end else if (state_q == uep0_pkg::DEV_ADDRESSED && ep == 4'd0) begin
            is_data  = 1'b1;
            len_full = uep0_pkg::STATUS_LEN;
          end
        end
        uep0_pkg::REQ_CLR_FEAT_IF,
        uep0_pkg::REQ_SET_FEAT_IF: begin
          q_cmd_o.kind = uep0_pkg::RESP_ACK;
        end
        uep0_pkg::REQ_CLR_FEAT_EP,
        uep0_pkg::REQ_SET_FEAT_EP: begin
          if (in_item_i.setup_value == 16'h0000 && ep != 4'd0 && ep_ok) begin
            for (int i = 1; i < NUM_ENDPOINTS; i++) begin
              if (ep == 4'(i)) begin
                halt_d[i] = (in_item_i.setup_request == uep0_pkg::BREQ_SET_FEATURE);
              end
            end
            q_cmd_o.kind = uep0_pkg::RESP_ACK;
          end
        end
        default: begin
          q_cmd_o.kind = uep0_pkg::RESP_STALL;
        end
      endcase
    end

    // cut to wlength; nothing left means a zero-length acknowledge
    len_cut = (in_item_i.setup_length < {10'b0, len_full})
              ? in_item_i.setup_length[uep0_pkg::LEN_W-1:0] : len_full;
    if (is_data) begin
      q_cmd_o.kind = (len_cut == '0) ? uep0_pkg::RESP_ACK : uep0_pkg::RESP_DATA;
    end
    q_cmd_o.count        = len_cut;
    q_cmd_o.dev_address  = addr_d;
    q_cmd_o.dev_state    = state_d;
    q_cmd_o.config_value = conf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uep0_pkg::DEV_DEFAULT;
      addr_q  <= '0;
      conf_q  <= '0;
      halt_q  <= '1;
    end else if (q_push_o) begin
      state_q <= state_d;
      addr_q  <= addr_d;
      conf_q  <= conf_d;
      halt_q  <= halt_d;
    end
  end

  a_configured_has_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == uep0_pkg::DEV_CONFIGURED) |-> (conf_q != '0))
    else $error("configured state with zero configuration value");

endmodule

// File: rtl/uep0_cmd_fifo.sv
// short command queue between the decoder and the reply sequencer
module uep0_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  uep0_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output uep0_pkg::cmd_t cmd_o
);

  uep0_pkg::cmd_t                mem_q [uep0_pkg::Q_DEPTH];
  logic [uep0_pkg::Q_AW-1:0]     wr_q, wr_d;
  logic [uep0_pkg::Q_AW-1:0]     rd_q, rd_d;
  logic [uep0_pkg::Q_CW-1:0]     cnt_q, cnt_d;

  localparam logic [uep0_pkg::Q_AW-1:0] LAST_SLOT = uep0_pkg::Q_AW'(uep0_pkg::Q_DEPTH - 1);

  assign full_o  = (cnt_q == uep0_pkg::Q_CW'(uep0_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST_SLOT) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("command queue read while empty");

endmodule

// File: rtl/uep0_back.sv
// back end: plays out each command as reply results through an output register
module uep0_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                q_valid_i,
  input  uep0_pkg::cmd_t      q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  output uep0_pkg::out_item_t out_item_o,
  input  logic                out_stall_i
);

  logic [15:0]                 vid_q;
  logic [15:0]                 pid_q;
  logic [uep0_pkg::LEN_W-1:0]  idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  uep0_pkg::out_item_t         out_q, out_d;
  logic                        load;
  logic                        is_last;
  logic [uep0_pkg::ROM_AW-1:0] pos;
  logic [7:0]                  byte_val;

  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (q_cmd_i.kind != uep0_pkg::RESP_DATA)
                   || (uep0_pkg::LEN_W'(idx_q + 1'b1) == q_cmd_i.count);
  assign q_pop_o = load && is_last;
  assign pos     = q_cmd_i.start + uep0_pkg::ROM_AW'(idx_q);

  always_comb begin
    if (q_cmd_i.from_rom) begin
      if (pos == uep0_pkg::VID_LO_AT) begin
        byte_val = vid_q[7:0];
      end else if (pos == uep0_pkg::VID_HI_AT) begin
        byte_val = vid_q[15:8];
      end else if (pos == uep0_pkg::PID_LO_AT) begin
        byte_val = pid_q[7:0];
      end else if (pos == uep0_pkg::PID_HI_AT) begin
        byte_val = pid_q[15:8];
      end else begin
        byte_val = uep0_pkg::desc_rom(pos);
      end
    end else begin
      byte_val = (idx_q == '0) ? q_cmd_i.byte0 : 8'h00;
    end
  end

  always_comb begin
    out_d              = out_q;
    idx_d              = idx_q;
    out_valid_d        = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d        = 1'b1;
      out_d.resp_kind    = q_cmd_i.kind;
      out_d.data_byte    = (q_cmd_i.kind == uep0_pkg::RESP_DATA) ? byte_val : 8'h00;
      out_d.last         = is_last;
      out_d.dev_address  = q_cmd_i.dev_address;
      out_d.dev_state    = q_cmd_i.dev_state;
      out_d.config_value = q_cmd_i.config_value;
      idx_d              = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vid_q       <= '0;
      pid_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          uep0_pkg::CFG_VENDOR_ID:  vid_q <= cfg_wdata_i;
          uep0_pkg::CFG_PRODUCT_ID: pid_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_mid_reply_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (q_valid_i && q_cmd_i.kind == uep0_pkg::RESP_DATA))
    else $error("reply in progress without a data command at the queue head");

endmodule

// File: rtl/usb_ep0_standard_request_handler_core.sv
// top level of the usb control endpoint standard request handler
// with an idle back end a transaction is first written into the command queue, and its first result
//   is then registered in the output register
// one result per cycle while out_stall_i is low; a transaction gives 1 to 39 results, played out
//   by the reply sequencer that reads the descriptor rom a byte a cycle
// the two-entry command queue lets the decoder take transactions while replies drain
// reset: rst_ni clears device state, address, configuration and sets all halt marks
module usb_ep0_standard_request_handler_core #(
  parameter int unsigned NUM_ENDPOINTS = uep0_pkg::NUM_ENDPOINTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  // setup and bus-reset transactions
  input  logic                in_valid_i,
  input  uep0_pkg::in_item_t  in_item_i,
  output logic                in_stall_o,
  // reply transactions
  output logic                out_valid_o,
  output uep0_pkg::out_item_t out_item_o,
  input  logic                out_stall_i
);

  // front to queue
  logic           push;
  uep0_pkg::cmd_t push_cmd;
  logic           q_full;

  // queue to back
  logic           q_valid;
  uep0_pkg::cmd_t head_cmd;
  logic           pop;

  // decoder: classifies each transaction, updates device state, builds the command
  uep0_front #(
    .NUM_ENDPOINTS (NUM_ENDPOINTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  // decoupling queue so each side can stall on its own
  uep0_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // reply sequencer with the output register and identifier registers
  uep0_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule
